@@ hw/rtl/quadrature_decoder_four_channel_assert.svh @@
// Assertion macros for the quadrature decoder top level.
`ifndef QUADRATURE_DECODER_FOUR_CHANNEL_ASSERT_SVH
`define QUADRATURE_DECODER_FOUR_CHANNEL_ASSERT_SVH

// Check a property on clk, ignored while reset is held.
`define QDEC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on clk, also while reset is held.
`define QDEC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/qdec_pkg.sv @@
// Types, constants and the step decode table of the quadrature decoder.
package qdec_pkg;

    localparam int NUM_CHANNELS_DEF = 4;
    localparam int CH_W             = 2;
    localparam int TICK_W           = 16;
    localparam int DIST_W           = 32;
    localparam int MASK_W           = 4;
    localparam logic [MASK_W-1:0] INVERT_RESET = 4'd9;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_LATCH  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_READ   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STEP_NONE = 2'b00,
        STEP_UP   = 2'b01,
        STEP_DOWN = 2'b10
    } step_t;

    // Per-channel control; sample, latch and clear are set only in the cycle a request advances.
    typedef struct packed {
        logic       sample;
        logic       latch;
        logic       clear;
        logic       invert;
        logic [1:0] reading;
    } chan_ctl_t;

    // Per-channel counters as they stand after the current request.
    typedef struct packed {
        logic [TICK_W-1:0] tick_count;
        logic [TICK_W-1:0] speed;
        logic [DIST_W-1:0] abs_distance;
        logic [DIST_W-1:0] signed_distance;
    } chan_cnt_t;

    // x4 decode: previous reading, new reading -> step; double transitions give none.
    function automatic step_t step_decode(logic [1:0] prev, logic [1:0] cur);
        step_t s;
        case ({prev, cur}) inside
            4'b0010, 4'b0100, 4'b1011, 4'b1101: s = STEP_UP;
            4'b0001, 4'b0111, 4'b1000, 4'b1110: s = STEP_DOWN;
            default:                            s = STEP_NONE;
        endcase
        return s;
    endfunction

endpackage

@@ hw/rtl/qdec_ifs.sv @@
// Valid/ready channel interfaces for phase sample requests and results.
interface qdec_in_if import qdec_pkg::*; ();
    logic          valid;
    logic          ready;
    opcode_t       opcode;
    logic [CH_W-1:0] channel;
    logic          phase_hi;
    logic          phase_lo;

    modport source (output valid, output opcode, output channel,
                    output phase_hi, output phase_lo, input ready);
    modport sink   (input valid, input opcode, input channel,
                    input phase_hi, input phase_lo, output ready);
endinterface

interface qdec_out_if import qdec_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [TICK_W-1:0] tick_count;
    logic signed [TICK_W-1:0] speed;
    logic [DIST_W-1:0]        abs_distance;
    logic signed [DIST_W-1:0] signed_distance;
    logic                     moving;

    modport source (output valid, output tick_count, output speed,
                    output abs_distance, output signed_distance,
                    output moving, input ready);
    modport sink   (input valid, input tick_count, input speed,
                    input abs_distance, input signed_distance,
                    input moving, output ready);
endinterface

@@ hw/rtl/qdec_chan.sv @@
// One encoder channel: step decode and its tick, speed and distance counters.
module qdec_chan import qdec_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  chan_ctl_t ctl,
    output chan_cnt_t cnt_next
);

    logic [1:0]        last_phase_reg;
    logic [1:0]        last_phase_next;
    logic [TICK_W-1:0] tick_reg;
    logic [TICK_W-1:0] tick_next;
    logic [TICK_W-1:0] speed_reg;
    logic [TICK_W-1:0] speed_next;
    logic [DIST_W-1:0] abs_reg;
    logic [DIST_W-1:0] abs_next;
    logic [DIST_W-1:0] net_reg;
    logic [DIST_W-1:0] net_next;
    step_t             raw_step;
    logic              go_up;
    logic              go_down;

    // Decode the step and apply the channel's inversion
    assign raw_step = step_decode(last_phase_reg, ctl.reading);
    assign go_up    = ctl.sample && (ctl.invert ? raw_step == STEP_DOWN : raw_step == STEP_UP);
    assign go_down  = ctl.sample && (ctl.invert ? raw_step == STEP_UP : raw_step == STEP_DOWN);

    // Advance the counters for this request
    always_comb
    begin
        last_phase_next = ctl.sample ? ctl.reading : last_phase_reg;
        tick_next       = tick_reg;
        speed_next      = speed_reg;
        abs_next        = abs_reg;
        net_next        = net_reg;
        if (go_up)
        begin
            tick_next = tick_reg + TICK_W'(1);
            net_next  = net_reg + DIST_W'(1);
            abs_next  = abs_reg + DIST_W'(1);
        end
        else if (go_down)
        begin
            tick_next = tick_reg - TICK_W'(1);
            net_next  = net_reg - DIST_W'(1);
            abs_next  = abs_reg + DIST_W'(1);
        end
        if (ctl.latch)
        begin
            speed_next = tick_reg;
            tick_next  = '0;
        end
        if (ctl.clear)
        begin
            abs_next = '0;
        end
    end

    assign cnt_next = '{tick_count:      tick_next,
                        speed:           speed_next,
                        abs_distance:    abs_next,
                        signed_distance: net_next};

    // Hold the channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_phase_reg <= '0;
            tick_reg       <= '0;
            speed_reg      <= '0;
            abs_reg        <= '0;
            net_reg        <= '0;
        end
        else
        begin
            last_phase_reg <= last_phase_next;
            tick_reg       <= tick_next;
            speed_reg      <= speed_next;
            abs_reg        <= abs_next;
            net_reg        <= net_next;
        end
    end

endmodule

@@ hw/rtl/quadrature_decoder_four_channel.sv @@
// Top level of the four-channel x4 quadrature encoder decoder.
//
// Requests enter on the sample channel (valid/ready): an opcode, a channel
// number and the two phase levels. Opcodes: phase sample, period tick (latch
// every tick count into speed and clear the counts), clear absolute
// distances, and read only. Each request gives exactly one response on the
// result channel with the addressed channel's tick count, latched speed,
// absolute and signed distance, and a flag set when any latched speed is
// nonzero. Channels numbered NUM_CHANNELS or above read as zero counters.
// invert_mask is written through invert_mask_we/invert_mask_wdata; the user
// must write it only while idle, which the block itself does not enforce. A
// request in the request register moves into the result register once the
// result slot is free, and its response is then valid. The block takes one
// request per cycle while the result side does not stall.
// Reset clears all counters and the phase history, empties both pipeline
// registers, and loads invert_mask with 4'b1001. When result.ready is low the
// result register holds, one more request may wait in the request register,
// and sample.ready drops only when both are full.
module quadrature_decoder_four_channel import qdec_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    qdec_in_if.sink           sample,
    qdec_out_if.source        result,
    input  logic              invert_mask_we,
    input  logic [MASK_W-1:0] invert_mask_wdata
);

    `include "quadrature_decoder_four_channel_assert.svh"

    logic [MASK_W-1:0]  invert_mask_reg;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    opcode_t            s1_opcode_reg;
    logic [CH_W-1:0]    s1_channel_reg;
    logic [1:0]         s1_reading_reg;
    logic               s1_advance;
    logic               in_accept;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [TICK_W-1:0]  out_tick_reg;
    logic [TICK_W-1:0]  out_speed_reg;
    logic [DIST_W-1:0]  out_abs_reg;
    logic [DIST_W-1:0]  out_net_reg;
    logic               out_moving_reg;

    chan_ctl_t          ctl [NUM_CHANNELS];
    chan_cnt_t          cnt_next [NUM_CHANNELS];
    chan_cnt_t          sel_cnt;
    logic               any_moving;

    // Handshake: the request register moves on whenever the result slot frees
    assign s1_advance     = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready   = !s1_valid_reg || s1_advance;
    assign in_accept      = sample.valid && sample.ready;
    assign s1_valid_next  = in_accept || (s1_valid_reg && !s1_advance);
    assign out_valid_next = s1_advance || (out_valid_reg && !result.ready);

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_mask_reg <= INVERT_RESET;
        end
        else if (invert_mask_we)
        begin
            invert_mask_reg <= invert_mask_wdata;
        end
    end

    // Request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_opcode_reg  <= sample.opcode;
            s1_channel_reg <= sample.channel;
            s1_reading_reg <= {sample.phase_hi, sample.phase_lo};
        end
    end

    // Channel cells
    for (genvar c = 0; c < NUM_CHANNELS; c++)
    begin : g_chan
        logic inv;
        if (c < MASK_W)
        begin : g_mask
            assign inv = invert_mask_reg[c];
        end
        else
        begin : g_nomask
            assign inv = 1'b0;
        end

        assign ctl[c] = '{sample:  s1_advance && s1_opcode_reg == OP_SAMPLE
                                   && int'(s1_channel_reg) == c,
                          latch:   s1_advance && s1_opcode_reg == OP_LATCH,
                          clear:   s1_advance && s1_opcode_reg == OP_CLEAR,
                          invert:  inv,
                          reading: s1_reading_reg};

        qdec_chan u_chan (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl[c]),
            .cnt_next (cnt_next[c])
        );
    end

    // Select the addressed channel and gather the moving flag
    always_comb
    begin
        sel_cnt    = '0;
        any_moving = 1'b0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            if (int'(s1_channel_reg) == c)
            begin
                sel_cnt = cnt_next[c];
            end
            any_moving = any_moving || (cnt_next[c].speed != '0);
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_tick_reg   <= sel_cnt.tick_count;
            out_speed_reg  <= sel_cnt.speed;
            out_abs_reg    <= sel_cnt.abs_distance;
            out_net_reg    <= sel_cnt.signed_distance;
            out_moving_reg <= any_moving;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.tick_count      = out_tick_reg;
    assign result.speed           = out_speed_reg;
    assign result.abs_distance    = out_abs_reg;
    assign result.signed_distance = out_net_reg;
    assign result.moving          = out_moving_reg;

    `QDEC_ASSERT(a_advance_fills_result, s1_advance |=> out_valid_reg, "advanced request did not reach the result register")
    `QDEC_ASSERT(a_stall_keeps_request, s1_valid_reg && out_valid_reg && !result.ready |=> s1_valid_reg, "pending request lost under stall")
    `QDEC_ASSERT(a_latch_clears_ticks, s1_advance && s1_opcode_reg == OP_LATCH |=> out_tick_reg == '0, "tick count not cleared by period tick")
    `QDEC_ASSERT_ALWAYS(a_ready_when_empty, !s1_valid_reg |-> sample.ready, "request register empty but not ready")

endmodule

@@ tb/quadrature_decoder_four_channel_test.sv @@
// Self-checking testbench for the four-channel quadrature decoder.
module quadrature_decoder_four_channel_test import qdec_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS         = 4;
    localparam int NUM_PHASES       = 6;
    localparam int ITEMS_PER_PHASE  = 255;
    localparam int DRAIN_CYCLES     = 6;
    localparam int CYCLE_LIMIT      = 600000;

    // Step per (previous reading, new reading); double transitions give none.
    localparam int signed STEP_BY_TRANSITION [16] = '{
        0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0
    };

    typedef struct packed {
        logic signed [TICK_W-1:0] tick;
        logic signed [TICK_W-1:0] spd;
        logic [DIST_W-1:0]        abs_d;
        logic signed [DIST_W-1:0] net_d;
        logic                     mov;
    } dec_result_t;

    typedef struct packed {
        opcode_t     op;
        logic [1:0]  ch;
        logic        hi;
        logic        lo;
        logic        typed;
        dec_result_t want;
    } stim_row_t;

    localparam dec_result_t ZERO_RESULT = '0;
    localparam int NUM_ROWS = 23;

    // Directed requests; mask is at its reset value, channels 0 and 3 inverted.
    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{OP_READ,   2'd0, 1'b0, 1'b0, 1'b1, ZERO_RESULT},
        '{OP_READ,   2'd3, 1'b1, 1'b1, 1'b1, ZERO_RESULT},
        '{OP_SAMPLE, 2'd2, 1'b1, 1'b1, 1'b1, ZERO_RESULT},  // double transition
        '{OP_SAMPLE, 2'd1, 1'b1, 1'b0, 1'b0, ZERO_RESULT},
        '{OP_SAMPLE, 2'd1, 1'b1, 1'b1, 1'b0, ZERO_RESULT},
        '{OP_SAMPLE, 2'd1, 1'b0, 1'b1, 1'b0, ZERO_RESULT},
        '{OP_SAMPLE, 2'd1, 1'b0, 1'b0, 1'b0, ZERO_RESULT},
        '{OP_SAMPLE, 2'd1, 1'b0, 1'b0, 1'b0, ZERO_RESULT},  // no change
        '{OP_SAMPLE, 2'd1, 1'b0, 1'b1, 1'b0, ZERO_RESULT},
        '{OP_SAMPLE, 2'd0, 1'b1, 1'b0, 1'b0, ZERO_RESULT},  // inverted channel
        '{OP_SAMPLE, 2'd0, 1'b1, 1'b1, 1'b0, ZERO_RESULT},
        '{OP_SAMPLE, 2'd3, 1'b0, 1'b1, 1'b0, ZERO_RESULT},
        '{OP_SAMPLE, 2'd3, 1'b1, 1'b0, 1'b0, ZERO_RESULT},  // double transition
        '{OP_SAMPLE, 2'd2, 1'b1, 1'b0, 1'b0, ZERO_RESULT},
        '{OP_LATCH,  2'd1, 1'b0, 1'b0, 1'b0, ZERO_RESULT},
        '{OP_READ,   2'd0, 1'b1, 1'b1, 1'b0, ZERO_RESULT},
        '{OP_SAMPLE, 2'd2, 1'b0, 1'b0, 1'b0, ZERO_RESULT},
        '{OP_CLEAR,  2'd2, 1'b0, 1'b0, 1'b0, ZERO_RESULT},
        '{OP_READ,   2'd1, 1'b0, 1'b1, 1'b0, ZERO_RESULT},
        '{OP_READ,   2'd3, 1'b1, 1'b0, 1'b0, ZERO_RESULT},
        '{OP_LATCH,  2'd2, 1'b1, 1'b1, 1'b0, ZERO_RESULT},
        '{OP_LATCH,  2'd0, 1'b0, 1'b1, 1'b0, ZERO_RESULT},  // all counts zero
        '{OP_READ,   2'd2, 1'b1, 1'b0, 1'b0, ZERO_RESULT}
    };

    logic clk;
    logic rst_n;
    logic invert_mask_we;
    logic [MASK_W-1:0] invert_mask_wdata;

    qdec_in_if  sample_if ();
    qdec_out_if result_if ();

    // Decoder state as the block should hold it
    logic [1:0]          prev_reading [CHANNELS];
    logic [TICK_W-1:0]   tick_acc     [CHANNELS];
    logic [TICK_W-1:0]   speed_hold   [CHANNELS];
    logic [DIST_W-1:0]   abs_steps    [CHANNELS];
    logic [DIST_W-1:0]   net_pos      [CHANNELS];
    logic [MASK_W-1:0]   invert_bits;
    bit                  drive_up     [CHANNELS];

    dec_result_t pending_results [$];
    int          fail_count;
    int          cycle_count;
    bit          quiet_phase;

    quadrature_decoder_four_channel i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .sample            (sample_if),
        .result            (result_if),
        .invert_mask_we    (invert_mask_we),
        .invert_mask_wdata (invert_mask_wdata)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Apply one request to the decoder state and return the addressed counters
    function automatic dec_result_t decode_request(opcode_t op, logic [1:0] ch,
                                                   logic [1:0] reading);
        dec_result_t res;
        int signed   stp;
        int          c;
        stp = 0;
        case (op)
            OP_SAMPLE:
            begin
                stp = STEP_BY_TRANSITION[{prev_reading[ch], reading}];
                if (invert_bits[ch])
                    stp = -stp;
                if (stp > 0)
                begin
                    tick_acc[ch]  = tick_acc[ch] + 1'b1;
                    net_pos[ch]   = net_pos[ch] + 1'b1;
                    abs_steps[ch] = abs_steps[ch] + 1'b1;
                end
                else if (stp < 0)
                begin
                    tick_acc[ch]  = tick_acc[ch] - 1'b1;
                    net_pos[ch]   = net_pos[ch] - 1'b1;
                    abs_steps[ch] = abs_steps[ch] + 1'b1;
                end
                prev_reading[ch] = reading;
            end
            OP_LATCH:
            begin
                for (c = 0; c < CHANNELS; c++)
                begin
                    speed_hold[c] = tick_acc[c];
                    tick_acc[c]   = '0;
                end
            end
            OP_CLEAR:
            begin
                for (c = 0; c < CHANNELS; c++)
                    abs_steps[c] = '0;
            end
            default:
            begin
            end
        endcase
        res.tick  = tick_acc[ch];
        res.spd   = speed_hold[ch];
        res.abs_d = abs_steps[ch];
        res.net_d = net_pos[ch];
        res.mov   = 1'b0;
        for (c = 0; c < CHANNELS; c++)
            if (speed_hold[c] != '0)
                res.mov = 1'b1;
        return res;
    endfunction

    // Next reading one x4 step along the Gray sequence 00, 10, 11, 01
    function automatic logic [1:0] gray_step(logic [1:0] r, bit up);
        logic [1:0] nxt;
        case (r)
            2'b00:   nxt = up ? 2'b10 : 2'b01;
            2'b10:   nxt = up ? 2'b11 : 2'b00;
            2'b11:   nxt = up ? 2'b01 : 2'b10;
            default: nxt = up ? 2'b00 : 2'b11;
        endcase
        return nxt;
    endfunction

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one request, hold it until taken, then record its expected result
    task automatic send_request(opcode_t op, logic [1:0] ch, logic hi, logic lo,
                                logic typed, dec_result_t want);
        int          gap;
        dec_result_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_if.valid    <= 1'b1;
        sample_if.opcode   <= op;
        sample_if.channel  <= ch;
        sample_if.phase_hi <= hi;
        sample_if.phase_lo <= lo;
        do
            @(posedge clk);
        while (!sample_if.ready);
        predicted = decode_request(op, ch, {hi, lo});
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Write the invert mask once every result has drained
    task automatic write_invert_mask(logic [MASK_W-1:0] mask);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        invert_mask_we    <= 1'b1;
        invert_mask_wdata <= mask;
        @(posedge clk);
        invert_mask_we    <= 1'b0;
        invert_bits = mask;
    endtask

    // Build one random request, mostly well-formed quadrature motion
    task automatic send_random_request();
        int         r;
        logic [1:0] ch;
        logic [1:0] rd;
        opcode_t    op;
        r  = $urandom_range(0, 99);
        ch = 2'($urandom_range(0, CHANNELS - 1));
        rd = 2'($urandom_range(0, 3));
        op = OP_SAMPLE;
        if (r < 70)
            rd = gray_step(prev_reading[ch],
                           ($urandom_range(0, 3) != 0) ? drive_up[ch] : !drive_up[ch]);
        else if (r < 78)
            rd = prev_reading[ch];
        else if (r < 84)
            rd = prev_reading[ch] ^ 2'b11;
        else if (r < 90)
            op = OP_LATCH;
        else if (r < 94)
            op = OP_CLEAR;
        else
            op = OP_READ;
        send_request(op, ch, rd[1], rd[0], 1'b0, ZERO_RESULT);
    endtask

    // Compare one result field and count a mismatch
    function automatic void check_field(string name, logic signed [63:0] want,
                                        logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Check every accepted result against the oldest expectation
    always @(posedge clk)
    begin
        dec_result_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("tick_count", want.tick, result_if.tick_count);
                check_field("speed", want.spd, result_if.speed);
                check_field("abs_distance", {32'b0, want.abs_d},
                            {32'b0, result_if.abs_distance});
                check_field("signed_distance", want.net_d, result_if.signed_distance);
                check_field("moving", {63'b0, want.mov}, {63'b0, result_if.moving});
            end
        end
    end

    // Drop the run if it hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("quadrature_decoder_four_channel_test NOT OK");
            $finish;
        end
    end

    // Stall the result side at random
    initial
    begin
        int stall;
        result_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Main sequence: reset, directed rows, then random phases under new masks
    initial
    begin
        logic [MASK_W-1:0] phase_masks [NUM_PHASES];
        int p;
        int n;
        int c;
        rst_n              <= 1'b0;
        invert_mask_we     <= 1'b0;
        invert_mask_wdata  <= '0;
        sample_if.valid    <= 1'b0;
        sample_if.opcode   <= OP_READ;
        sample_if.channel  <= '0;
        sample_if.phase_hi <= 1'b0;
        sample_if.phase_lo <= 1'b0;
        fail_count  = 0;
        quiet_phase = 1'b0;
        invert_bits = INVERT_RESET;
        for (c = 0; c < CHANNELS; c++)
        begin
            prev_reading[c] = '0;
            tick_acc[c]     = '0;
            speed_hold[c]   = '0;
            abs_steps[c]    = '0;
            net_pos[c]      = '0;
        end
        phase_masks = '{4'h0, 4'hF, 4'h6, 4'($urandom), 4'($urandom), INVERT_RESET};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < NUM_ROWS; n++)
            send_request(DIRECTED_ROWS[n].op, DIRECTED_ROWS[n].ch, DIRECTED_ROWS[n].hi,
                         DIRECTED_ROWS[n].lo, DIRECTED_ROWS[n].typed,
                         DIRECTED_ROWS[n].want);
        sample_if.valid <= 1'b0;

        // Counts accumulated so far must survive each mask change
        for (p = 0; p < NUM_PHASES; p++)
        begin
            write_invert_mask(phase_masks[p]);
            quiet_phase = (p == 2);
            for (c = 0; c < CHANNELS; c++)
                drive_up[c] = 1'($urandom);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                send_random_request();
            sample_if.valid <= 1'b0;
        end

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("quadrature_decoder_four_channel_test OK");
        else
            $display("quadrature_decoder_four_channel_test NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/qdec_pkg.sv
hw/rtl/qdec_ifs.sv
hw/rtl/qdec_chan.sv
hw/rtl/quadrature_decoder_four_channel.sv
tb/quadrature_decoder_four_channel_test.sv
